// ===== hdl/dfcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dfcb_pkg: shared types and constants for the depth fog color blend
// Fixed-point widths, register map codes, fog mode codes and the item
// record that travels down the pipeline.
// ----------------------------------------------------------------------------
package dfcb_pkg;

	localparam int CW = 16;          // color channel width, Q4.12
	localparam int DW = 32;          // distance width, Q24.8
	localparam int AW = 16;          // fog amount width, Q0.16
	localparam int QW = 17;          // alpha width, Q1.16
	localparam int DIV_STEPS = 16;   // quotient bits of the alpha divider
	localparam int SQ_STEPS = 17;    // root bits of the circular shaper
	localparam int SQ_VW = 2 * SQ_STEPS;
	localparam int SQ_RW = SQ_STEPS + 2;
	localparam logic [QW-1:0] ONE_Q16 = 17'h10000;
	localparam logic [15:0] HALF_Q16 = 16'h8000;

	typedef logic [CW-1:0] color_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_QUAD   = 2'd2,
		MODE_CIRC   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_NEAR     = 3'd1,
		REG_FAR      = 3'd2,
		REG_NEAR_AMT = 3'd3,
		REG_FAR_AMT  = 3'd4,
		REG_COLOR    = 3'd5,
		REG_BACKDROP = 3'd6
	} reg_idx_t;

	typedef struct packed {
		mode_t          fog_mode;
		logic [DW-1:0]  near_distance;
		logic [DW-1:0]  far_distance;
		logic [AW-1:0]  near_amount;
		logic [AW-1:0]  far_amount;
		logic [47:0]    fog_color;
		logic           use_backdrop;
	} cfg_t;

	typedef struct packed {
		logic           pass;
		logic           op;
		mode_t          mode;
		color_t [2:0]   col;
		color_t [2:0]   fc;
	} item_t;

endpackage

// ===== hdl/dfcb_cfg.sv =====
// ----------------------------------------------------------------------------
// dfcb_cfg: configuration register file
// APB-style write and read access to the fog registers, 8-byte spacing.
// ----------------------------------------------------------------------------
module dfcb_cfg import dfcb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	reg_idx_t idx;
	logic     wr;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fog_mode      <= MODE_NONE;
			cfg_q.near_distance <= '0;
			cfg_q.far_distance  <= DW'(256);
			cfg_q.near_amount   <= '0;
			cfg_q.far_amount    <= '1;
			cfg_q.fog_color     <= '0;
			cfg_q.use_backdrop  <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_MODE:     cfg_q.fog_mode      <= mode_t'(pwdata[1:0]);
				REG_NEAR:     cfg_q.near_distance <= pwdata[DW-1:0];
				REG_FAR:      cfg_q.far_distance  <= pwdata[DW-1:0];
				REG_NEAR_AMT: cfg_q.near_amount   <= pwdata[AW-1:0];
				REG_FAR_AMT:  cfg_q.far_amount    <= pwdata[AW-1:0];
				REG_COLOR:    cfg_q.fog_color     <= pwdata[47:0];
				REG_BACKDROP: cfg_q.use_backdrop  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_MODE:     prdata = 64'(cfg_q.fog_mode);
			REG_NEAR:     prdata = 64'(cfg_q.near_distance);
			REG_FAR:      prdata = 64'(cfg_q.far_distance);
			REG_NEAR_AMT: prdata = 64'(cfg_q.near_amount);
			REG_FAR_AMT:  prdata = 64'(cfg_q.far_amount);
			REG_COLOR:    prdata = 64'(cfg_q.fog_color);
			REG_BACKDROP: prdata = 64'(cfg_q.use_backdrop);
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== hdl/dfcb_div.sv =====
// ----------------------------------------------------------------------------
// dfcb_div: pipelined alpha divider
// Restoring division of diff * 2^16 by the fog length, one quotient bit
// per stage, with overrides for samples before near and beyond far.
// ----------------------------------------------------------------------------
module dfcb_div import dfcb_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_in,
	input  item_t          itm_in,
	input  logic [DW-1:0]  diff_in,
	input  logic           zero_in,
	input  logic           full_in,
	input  logic [DW-1:0]  len,
	output logic           vld_out,
	output item_t          itm_out,
	output logic [QW-1:0]  alpha_out
);

	logic                 vld_s  [DIV_STEPS];
	item_t                itm_s  [DIV_STEPS];
	logic [DW-1:0]        rem_s  [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_s  [DIV_STEPS];
	logic                 zero_s [DIV_STEPS];
	logic                 full_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic                 vld_p;
		item_t                itm_p;
		logic [DW-1:0]        rem_p;
		logic [DIV_STEPS-1:0] quo_p;
		logic                 zero_p;
		logic                 full_p;
		logic [DW:0]          r2;
		logic                 ge;

		if (k == 0) begin : g_first
			assign vld_p  = vld_in;
			assign itm_p  = itm_in;
			assign rem_p  = diff_in;
			assign quo_p  = '0;
			assign zero_p = zero_in;
			assign full_p = full_in;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign itm_p  = itm_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign zero_p = zero_s[k-1];
			assign full_p = full_s[k-1];
		end

		assign r2 = {rem_p, 1'b0};
		assign ge = r2 >= {1'b0, len};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[k]  <= itm_p;
				rem_s[k]  <= ge ? DW'(r2 - {1'b0, len}) : DW'(r2);
				quo_s[k]  <= {quo_p[DIV_STEPS-2:0], ge};
				zero_s[k] <= zero_p;
				full_s[k] <= full_p;
			end
		end
	end

	assign vld_out   = vld_s[DIV_STEPS-1];
	assign itm_out   = itm_s[DIV_STEPS-1];
	assign alpha_out = zero_s[DIV_STEPS-1] ? '0 :
		full_s[DIV_STEPS-1] ? ONE_Q16 : QW'(quo_s[DIV_STEPS-1]);

endmodule

// ===== hdl/dfcb_sqrt.sv =====
// ----------------------------------------------------------------------------
// dfcb_sqrt: pipelined integer square root
// Digit-by-digit root of the circular shaping term, one root bit per
// stage; the linear or quadratic alpha rides alongside.
// ----------------------------------------------------------------------------
module dfcb_sqrt import dfcb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  item_t             itm_in,
	input  logic [SQ_VW-1:0]  v_in,
	input  logic [QW-1:0]     sel_in,
	output logic              vld_out,
	output item_t             itm_out,
	output logic [QW-1:0]     root_out,
	output logic [QW-1:0]     sel_out
);

	logic                vld_s  [SQ_STEPS];
	item_t               itm_s  [SQ_STEPS];
	logic [SQ_VW-1:0]    v_s    [SQ_STEPS];
	logic [SQ_RW-1:0]    rem_s  [SQ_STEPS];
	logic [SQ_STEPS-1:0] root_s [SQ_STEPS];
	logic [QW-1:0]       sel_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		logic                vld_p;
		item_t               itm_p;
		logic [SQ_VW-1:0]    v_p;
		logic [SQ_RW-1:0]    rem_p;
		logic [SQ_STEPS-1:0] root_p;
		logic [QW-1:0]       sel_p;
		logic [SQ_RW+1:0]    t;
		logic [SQ_RW-1:0]    tst;
		logic                ge;

		if (k == 0) begin : g_first
			assign vld_p  = vld_in;
			assign itm_p  = itm_in;
			assign v_p    = v_in;
			assign rem_p  = '0;
			assign root_p = '0;
			assign sel_p  = sel_in;
		end else begin : g_next
			assign vld_p  = vld_s[k-1];
			assign itm_p  = itm_s[k-1];
			assign v_p    = v_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign sel_p  = sel_s[k-1];
		end

		assign t   = {rem_p, v_p[SQ_VW-1-2*k -: 2]};
		assign tst = {root_p, 2'b01};
		assign ge  = t >= {2'b00, tst};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[k]  <= itm_p;
				v_s[k]    <= v_p;
				rem_s[k]  <= ge ? SQ_RW'(t - {2'b00, tst}) : SQ_RW'(t);
				root_s[k] <= {root_p[SQ_STEPS-2:0], ge};
				sel_s[k]  <= sel_p;
			end
		end
	end

	assign vld_out  = vld_s[SQ_STEPS-1];
	assign itm_out  = itm_s[SQ_STEPS-1];
	assign root_out = QW'(root_s[SQ_STEPS-1]);
	assign sel_out  = sel_s[SQ_STEPS-1];

endmodule

// ===== hdl/depth_fog_color_blend.sv =====
// Throughput: one sample per cycle; the 16-stage divider and 17-stage
// square root are fully pipelined, one quotient or root bit per stage.
// The whole pipeline holds when the output is valid and not taken.
// Reset is asynchronous, active low; it clears the valid bits and loads
// the register defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// depth_fog_color_blend: distance fog for RGB shading samples
// Computes a fog amount from ray distance and blends or fades the color.
// ----------------------------------------------------------------------------
module depth_fog_color_blend import dfcb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// distance, red_in, green_in, blue_in, backdrop_red, backdrop_green,
	// backdrop_blue
	input  logic [127:0] s_tdata,
	// operation, at_infinity
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// red_out, green_out, blue_out, fog_amount
	output logic [63:0]  m_tdata
);

	cfg_t          cfg;
	logic          en;
	logic [DW-1:0] len;
	item_t         itm_in;
	logic [DW-1:0] sample_dist;

	dfcb_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign len = (cfg.far_distance > cfg.near_distance) ?
		cfg.far_distance - cfg.near_distance : DW'(1);
	assign sample_dist = s_tdata[DW-1:0];

	always_comb begin
		itm_in.pass = (cfg.fog_mode == MODE_NONE) || s_tuser[1];
		itm_in.op   = s_tuser[0];
		itm_in.mode = cfg.fog_mode;
		for (int i = 0; i < 3; i++) begin
			itm_in.col[2-i] = s_tdata[DW+i*CW +: CW];
			itm_in.fc[2-i]  = cfg.use_backdrop ? s_tdata[DW+(3+i)*CW +: CW] :
				cfg.fog_color[(2-i)*CW +: CW];
		end
	end

	// Stage 1: offset from near; stage 2: beyond-far check.
	logic          vld_s1, vld_s2;
	item_t         itm_s1, itm_s2;
	logic [DW-1:0] diff_s1, diff_s2;
	logic          zero_s1, zero_s2, full_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s1  <= itm_in;
			diff_s1 <= sample_dist - cfg.near_distance;
			zero_s1 <= sample_dist <= cfg.near_distance;
			itm_s2  <= itm_s1;
			diff_s2 <= diff_s1;
			zero_s2 <= zero_s1;
			full_s2 <= diff_s1 >= len;
		end
	end

	logic          d_vld;
	item_t         d_itm;
	logic [QW-1:0] d_alpha;

	dfcb_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s2), .itm_in(itm_s2),
		.diff_in(diff_s2), .zero_in(zero_s2), .full_in(full_s2), .len(len),
		.vld_out(d_vld), .itm_out(d_itm), .alpha_out(d_alpha)
	);

	// Stage 3: one multiplier serves both shaping curves.
	// Quadratic squares (1 - a); circular forms a * (2 - a).
	logic             vld_s3;
	item_t            itm_s3;
	logic [SQ_VW-1:0] p_s3;
	logic [QW-1:0]    a_s3;
	logic [QW:0]      ma, mb;
	logic [2*QW+1:0]  prod;
	logic [QW-1:0]    sel_in;

	assign ma   = (d_itm.mode == MODE_QUAD) ? {1'b0, QW'(ONE_Q16 - d_alpha)} :
		{1'b0, d_alpha};
	assign mb   = (d_itm.mode == MODE_QUAD) ? {1'b0, QW'(ONE_Q16 - d_alpha)} :
		(QW+1)'(2 * ONE_Q16) - {1'b0, d_alpha};
	assign prod = (2*QW+2)'(ma) * (2*QW+2)'(mb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s3 <= d_itm;
			p_s3   <= prod[SQ_VW-1:0];
			a_s3   <= d_alpha;
		end
	end

	assign sel_in = (itm_s3.mode == MODE_QUAD) ? QW'(ONE_Q16 - p_s3[32:16]) : a_s3;

	logic          q_vld;
	item_t         q_itm;
	logic [QW-1:0] q_root, q_sel, al;

	dfcb_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3), .itm_in(itm_s3),
		.v_in(p_s3), .sel_in(sel_in), .vld_out(q_vld), .itm_out(q_itm),
		.root_out(q_root), .sel_out(q_sel)
	);

	assign al = (q_itm.mode == MODE_CIRC) ? q_root : q_sel;

	// Stages 5 to 8: fog amount lerp, then the color mix.
	logic                vld_s5, vld_s6, vld_s7, vld_s8;
	item_t               itm_s5, itm_s6, itm_s7;
	logic [AW+QW-1:0]    mn_s5, mf_s5;
	logic [AW-1:0]       fog_s6, fog_s7;
	logic [CW+QW-1:0]    cc_s7 [3];
	logic [CW+AW-1:0]    ff_s7 [3];
	logic [AW+QW:0]      fsum;
	logic [QW-1:0]       keep;
	color_t [2:0]        col_s8;
	logic [AW-1:0]       fog_s8;

	assign fsum = (AW+QW+1)'(mn_s5) + (AW+QW+1)'(mf_s5) + (AW+QW+1)'(HALF_Q16);
	assign keep = ONE_Q16 - QW'(fog_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s5 <= q_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			itm_s5 <= q_itm;
			mn_s5  <= (AW+QW)'(cfg.near_amount) * (AW+QW)'(QW'(ONE_Q16 - al));
			mf_s5  <= (AW+QW)'(cfg.far_amount) * (AW+QW)'(al);
			itm_s6 <= itm_s5;
			fog_s6 <= (|fsum[AW+QW:32]) ? '1 : fsum[31:16];
			itm_s7 <= itm_s6;
			fog_s7 <= fog_s6;
			for (int i = 0; i < 3; i++) begin
				cc_s7[i] <= (CW+QW)'(itm_s6.col[i]) * (CW+QW)'(keep);
				ff_s7[i] <= itm_s6.op ? '0 : (CW+AW)'(itm_s6.fc[i]) * (CW+AW)'(fog_s6);
			end
			for (int i = 0; i < 3; i++) begin
				logic [CW+QW:0] s;
				s = (CW+QW+1)'(cc_s7[i]) + (CW+QW+1)'(ff_s7[i]) + (CW+QW+1)'(HALF_Q16);
				if (itm_s7.pass) begin
					col_s8[i] <= itm_s7.col[i];
				end else begin
					col_s8[i] <= (|s[CW+QW:32]) ? '1 : s[31:16];
				end
			end
			fog_s8 <= itm_s7.pass ? '0 : fog_s7;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {fog_s8, col_s8[0], col_s8[1], col_s8[2]};

`ifndef SYNTH
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_vld |-> (al <= ONE_Q16))
		else $error("shaped alpha above one");
	a_pass_no_fog: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && itm_s7.pass && en) |=> (fog_s8 == '0))
		else $error("pass-through sample carries fog");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && vld_s7) |=> (vld_s7 && $stable(fog_s7)))
		else $error("pipeline moved during a stall");
`endif

endmodule
